// File: sv/p2p_pkg.sv
`timescale 1ns / 1ps
package p2p_pkg;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef enum logic [2:0] {
		REG_ROT0 = 3'd0,
		REG_ROT1 = 3'd1,
		REG_ROT2 = 3'd2,
		REG_TX = 3'd3,
		REG_TY = 3'd4,
		REG_TZ = 3'd5,
		REG_MODE = 3'd6
	} reg_idx_t;

	typedef logic signed [15:0] q14_t;
	typedef logic signed [31:0] q16_t;

	typedef struct packed {
		logic [1:0] row;
		q16_t err;
		q16_t jt0;
		q16_t jt1;
		q16_t jt2;
		q16_t jr0;
		q16_t jr1;
		q16_t jr2;
	} row_t;

	// saturate a wide signed value to 32 bits
	function automatic q16_t sat32(input logic signed [63:0] v);
		if (v > 64'(SAT_MAX))
			return SAT_MAX;
		else if (v < 64'(SAT_MIN))
			return SAT_MIN;
		else
			return v[31:0];
	endfunction
endpackage

// File: sv/p2p_core.sv
`timescale 1ns / 1ps
// four-stage arithmetic pipeline, one correspondence per beat
module p2p_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  p2p_pkg::q14_t r [3][3],
	input  p2p_pkg::q16_t t [3],
	input  p2p_pkg::q16_t p [3],
	input  p2p_pkg::q14_t n [3],
	input  p2p_pkg::q16_t q [3],
	input  p2p_pkg::q14_t m [3],
	output logic out_vld,
	output p2p_pkg::row_t rows [4]
);
	// stage 1: products
	logic vld_s1, vld_s2, vld_s3;
	logic signed [47:0] rp_s1 [3][3];
	logic signed [31:0] rn_s1 [3][3];
	logic signed [31:0] mr_s1 [3][3];
	logic signed [31:0] cn_s1 [3][3][2];
	p2p_pkg::q16_t t_s1 [3], p_s1 [3], q_s1 [3], p_s2 [3], q_s2 [3];
	p2p_pkg::q14_t m_s1 [3], m_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s1[i] <= t[i];
			p_s1[i] <= p[i];
			q_s1[i] <= q[i];
			m_s1[i] <= m[i];
			for (int j = 0; j < 3; j++) begin
				rp_s1[i][j] <= 48'(r[i][j]) * 48'(p[j]);
				rn_s1[i][j] <= 32'(r[i][j]) * 32'(n[j]);
				mr_s1[i][j] <= 32'(m[i]) * 32'(r[i][j]);
			end
			// cross terms of row i of r with n
			cn_s1[i][0][0] <= 32'(r[i][1]) * 32'(n[2]);
			cn_s1[i][0][1] <= 32'(r[i][2]) * 32'(n[1]);
			cn_s1[i][1][0] <= 32'(r[i][2]) * 32'(n[0]);
			cn_s1[i][1][1] <= 32'(r[i][0]) * 32'(n[2]);
			cn_s1[i][2][0] <= 32'(r[i][0]) * 32'(n[1]);
			cn_s1[i][2][1] <= 32'(r[i][1]) * 32'(n[0]);
		end
	end

	// stage 2: sums, transformed point, normal rows, a
	p2p_pkg::q16_t pp_s2 [3];
	logic signed [33:0] a_s2 [3];
	p2p_pkg::row_t nrow_s2 [3], nrow_s3 [3];

	always_ff @(posedge clk) begin
		logic signed [49:0] sp;
		logic signed [33:0] sn;
		logic signed [33:0] c;
		for (int i = 0; i < 3; i++) begin
			sp = 50'(rp_s1[i][0]) + 50'(rp_s1[i][1]) + 50'(rp_s1[i][2]);
			pp_s2[i] <= p2p_pkg::sat32(64'(sp >>> 14) + 64'(t_s1[i]));
			sn = 34'(rn_s1[i][0]) + 34'(rn_s1[i][1]) + 34'(rn_s1[i][2]);
			nrow_s2[i].row <= 2'(i + 1);
			nrow_s2[i].err <= p2p_pkg::sat32(64'((sn >>> 14) - 34'(m_s1[i])) <<< 2);
			nrow_s2[i].jt0 <= '0;
			nrow_s2[i].jt1 <= '0;
			nrow_s2[i].jt2 <= '0;
			c = 34'(cn_s1[i][0][0]) - 34'(cn_s1[i][0][1]);
			nrow_s2[i].jr0 <= p2p_pkg::sat32(64'((-(36'(c) <<< 1)) >>> 12));
			c = 34'(cn_s1[i][1][0]) - 34'(cn_s1[i][1][1]);
			nrow_s2[i].jr1 <= p2p_pkg::sat32(64'((-(36'(c) <<< 1)) >>> 12));
			c = 34'(cn_s1[i][2][0]) - 34'(cn_s1[i][2][1]);
			nrow_s2[i].jr2 <= p2p_pkg::sat32(64'((-(36'(c) <<< 1)) >>> 12));
			a_s2[i] <= 34'(mr_s1[0][i]) + 34'(mr_s1[1][i]) + 34'(mr_s1[2][i]);
			p_s2[i] <= p_s1[i];
			q_s2[i] <= q_s1[i];
			m_s2[i] <= m_s1[i];
		end
	end

	// stage 3: distance products and cross products with a14
	logic signed [49:0] dm_s3 [3];
	logic signed [51:0] ap_s3 [3][2];
	p2p_pkg::q16_t jt_s3 [3];

	always_ff @(posedge clk) begin
		logic signed [19:0] a14 [3];
		for (int i = 0; i < 3; i++)
			a14[i] = 20'(a_s2[i] >>> 14);
		for (int i = 0; i < 3; i++) begin
			dm_s3[i] <= 50'(m_s2[i]) * (50'(pp_s2[i]) - 50'(q_s2[i]));
			jt_s3[i] <= p2p_pkg::sat32(64'(a_s2[i] >>> 12));
			nrow_s3[i] <= nrow_s2[i];
		end
		ap_s3[0][0] <= 52'(a14[1]) * 52'(p_s2[2]);
		ap_s3[0][1] <= 52'(a14[2]) * 52'(p_s2[1]);
		ap_s3[1][0] <= 52'(a14[2]) * 52'(p_s2[0]);
		ap_s3[1][1] <= 52'(a14[0]) * 52'(p_s2[2]);
		ap_s3[2][0] <= 52'(a14[0]) * 52'(p_s2[1]);
		ap_s3[2][1] <= 52'(a14[1]) * 52'(p_s2[0]);
	end

	// stage 4: distance row, and the normal rows passed on
	always_ff @(posedge clk) begin
		logic signed [51:0] e;
		logic signed [54:0] c;
		e = 52'(dm_s3[0]) + 52'(dm_s3[1]) + 52'(dm_s3[2]);
		rows[0].row <= 2'd0;
		rows[0].err <= p2p_pkg::sat32(64'(e >>> 14));
		rows[0].jt0 <= jt_s3[0];
		rows[0].jt1 <= jt_s3[1];
		rows[0].jt2 <= jt_s3[2];
		c = 55'(ap_s3[0][0]) - 55'(ap_s3[0][1]);
		rows[0].jr0 <= p2p_pkg::sat32(64'((-(c <<< 1)) >>> 14));
		c = 55'(ap_s3[1][0]) - 55'(ap_s3[1][1]);
		rows[0].jr1 <= p2p_pkg::sat32(64'((-(c <<< 1)) >>> 14));
		c = 55'(ap_s3[2][0]) - 55'(ap_s3[2][1]);
		rows[0].jr2 <= p2p_pkg::sat32(64'((-(c <<< 1)) >>> 14));
		for (int i = 0; i < 3; i++)
			rows[i + 1] <= nrow_s3[i];
	end
endmodule

// File: sv/p2p_ser.sv
`timescale 1ns / 1ps
// row serializer: a result queue of four-row groups, one row per cycle
module p2p_ser #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  p2p_pkg::row_t rows [4],
	input  logic err_only,
	output logic full,
	output logic strobe,
	output p2p_pkg::row_t row_out,
	output logic last
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	p2p_pkg::row_t mem_q [DEPTH][4];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic [1:0] sub_q;
	logic pop;

	assign full = cnt_q >= (AW + 1)'(DEPTH - 4);
	assign pop = (cnt_q != '0) && (sub_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			sub_q <= '0;
			strobe <= 1'b0;
			last <= 1'b0;
		end else begin
			strobe <= cnt_q != '0;
			last <= pop;
			if (in_vld)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (cnt_q != '0)
				sub_q <= sub_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(in_vld) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		p2p_pkg::row_t rd;
		if (in_vld)
			for (int k = 0; k < 4; k++)
				mem_q[wp_q][k] <= rows[k];
		rd = mem_q[rp_q][sub_q];
		if (err_only) begin
			rd.jt0 = '0;
			rd.jt1 = '0;
			rd.jt2 = '0;
			rd.jr0 = '0;
			rd.jr1 = '0;
			rd.jr2 = '0;
		end
		row_out <= rd;
	end
endmodule

// File: sv/plane_to_plane_error_jacobian_top.sv
`timescale 1ns / 1ps
// channel | ports                                   | handshake
// input   | mov_*, fix_*                            | start & !busy
// result  | row_index, error_value, jac_*, last_row | strobe, one cycle, no stall
// config  | cfg_we, cfg_idx, cfg_data               | cfg_we, no wait
// a correspondence passes a four-stage multiply/add pipeline, then waits in a
// small result queue that sends its four rows on consecutive cycles
// the output port sets the rate: one row per strobe, four rows per correspondence
// busy rises while the queue cannot take every beat still in flight
// reset clears valid bits, queue pointers and the pose registers
module plane_to_plane_error_jacobian_top #(
	parameter int unsigned QDEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [47:0] cfg_data,
	input  logic signed [31:0] mov_px,
	input  logic signed [31:0] mov_py,
	input  logic signed [31:0] mov_pz,
	input  logic signed [15:0] mov_nx,
	input  logic signed [15:0] mov_ny,
	input  logic signed [15:0] mov_nz,
	input  logic signed [31:0] fix_px,
	input  logic signed [31:0] fix_py,
	input  logic signed [31:0] fix_pz,
	input  logic signed [15:0] fix_nx,
	input  logic signed [15:0] fix_ny,
	input  logic signed [15:0] fix_nz,
	output logic strobe,
	output logic [1:0] row_index,
	output logic signed [31:0] error_value,
	output logic signed [31:0] jac_tx,
	output logic signed [31:0] jac_ty,
	output logic signed [31:0] jac_tz,
	output logic signed [31:0] jac_rx,
	output logic signed [31:0] jac_ry,
	output logic signed [31:0] jac_rz,
	output logic last_row
);
	logic [47:0] rot_q [3];
	p2p_pkg::q16_t t_q [3];
	logic mode_q;

	// pose and mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				rot_q[i] <= '0;
				t_q[i] <= '0;
			end
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				p2p_pkg::REG_ROT0: rot_q[0] <= cfg_data;
				p2p_pkg::REG_ROT1: rot_q[1] <= cfg_data;
				p2p_pkg::REG_ROT2: rot_q[2] <= cfg_data;
				p2p_pkg::REG_TX: t_q[0] <= cfg_data[31:0];
				p2p_pkg::REG_TY: t_q[1] <= cfg_data[31:0];
				p2p_pkg::REG_TZ: t_q[2] <= cfg_data[31:0];
				p2p_pkg::REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	p2p_pkg::q14_t r [3][3];
	p2p_pkg::q16_t p [3], q [3];
	p2p_pkg::q14_t n [3], m [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = rot_q[i][16*j +: 16];
		p = '{mov_px, mov_py, mov_pz};
		q = '{fix_px, fix_py, fix_pz};
		n = '{mov_nx, mov_ny, mov_nz};
		m = '{fix_nx, fix_ny, fix_nz};
	end

	logic acc;
	logic core_vld;
	logic qfull;
	p2p_pkg::row_t rows [4];
	p2p_pkg::row_t ro;

	assign acc = start && !busy;
	// queue keeps room for the four beats the pipeline may hold
	assign busy = qfull;

	p2p_core u_core (
		.clk(clk), .arst_n(arst_n), .in_vld(acc),
		.r(r), .t(t_q), .p(p), .n(n), .q(q), .m(m),
		.out_vld(core_vld), .rows(rows)
	);

	p2p_ser #(.DEPTH(QDEPTH)) u_ser (
		.clk(clk), .arst_n(arst_n), .in_vld(core_vld), .rows(rows),
		.err_only(mode_q), .full(qfull), .strobe(strobe), .row_out(ro),
		.last(last_row)
	);

	assign row_index = ro.row;
	assign error_value = ro.err;
	assign jac_tx = ro.jt0;
	assign jac_ty = ro.jt1;
	assign jac_tz = ro.jt2;
	assign jac_rx = ro.jr0;
	assign jac_ry = ro.jr1;
	assign jac_rz = ro.jr2;

	a_last_row3: assert property (@(posedge clk) disable iff (!arst_n)
		last_row |-> strobe && row_index == 2'd3)
		else $error("last_row off row 3");
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && row_index != 2'd3 |=> strobe)
		else $error("row group broken");
	a_normal_jt: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && row_index != 2'd0 |-> jac_tx == '0 && jac_tz == '0)
		else $error("normal row translation term");
endmodule
